/* sv/nrtp_pkg.sv */
// types, codes and a helper function shared by the region profiler modules
// no dependencies
package nrtp_pkg;

   localparam int TS_W    = 48;
   localparam int SAVED_W = 64;
   localparam int ENT_W   = 32;
   localparam int MASK_W  = 7;
   localparam int KEY_W   = 3;
   localparam int STAT_W  = 2;
   localparam int DEPTH_W = 5;

   localparam logic [TS_W-1:0]  TICK_MAX = {TS_W{1'b1}};
   localparam logic [ENT_W-1:0] ENT_MAX  = {ENT_W{1'b1}};

   typedef enum logic [1:0] {
      REQ_BEGIN = 2'd0,
      REQ_END   = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_KEY = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_END  = 1'b1
   } state_type;

   // per-cycle command to every stack cell
   typedef struct packed {
      logic push;
      logic pop;
      logic sub;
   } cell_ctrl_type;

   // command to the per-key counter bank
   typedef struct packed {
      logic bump;
      logic add;
   } bank_cmd_type;

   // signed elapsed added to an unsigned total, clamped to [0, TICK_MAX]
   function automatic logic [TS_W-1:0] sat_add(input logic [TS_W-1:0] total,
                                               input logic [SAVED_W-1:0] e);
      logic signed [SAVED_W+1:0] sum;
      logic [TS_W-1:0]           res;
      sum = $signed({{(SAVED_W+2-TS_W){1'b0}}, total})
          + $signed({{2{e[SAVED_W-1]}}, e});
      if (sum <= 0) begin
         res = '0;
      end else if (sum >= $signed({{(SAVED_W+2-TS_W){1'b0}}, TICK_MAX})) begin
         res = TICK_MAX;
      end else begin
         res = sum[TS_W-1:0];
      end
      return res;
   endfunction

endpackage

/* sv/nested_region_time_profiler.sv */
// top level of the nested-region exclusive-time profiler
// depends on nrtp_pkg, nrtp_cell, nrtp_key_bank
//
// usage: a word is taken at a rising edge with start high and busy low. begin,
// read and unused words keep busy low, so they may follow each other on every
// cycle. an end word that pops an entry first pops the stack and captures the
// elapsed ticks of the top entry; in the next cycle it subtracts them in every
// stack cell at once and updates the key total unless the popped key's mask bit
// is clear; busy is high for that subtract cycle. every word gives exactly one
// result word in the cycle after its last cycle, marked by rsp_strobe for one
// cycle; there is no backpressure, so the receiver must take it then. the stack
// is a row of cells with the top always in cell 0, so push/pop are plain shifts.
module nested_region_time_profiler #(
   parameter int KEY_COUNT   = 6,
   parameter int STACK_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_type,
   input  logic [nrtp_pkg::KEY_W-1:0]   req_region_key,
   input  logic [nrtp_pkg::TS_W-1:0]    req_timestamp,
   // enable mask register
   input  logic                         csr_wr_en,
   input  logic [nrtp_pkg::MASK_W-1:0]  csr_wr_data,
   // result side
   output logic                         rsp_strobe,
   output logic [nrtp_pkg::STAT_W-1:0]  rsp_status,
   output logic [nrtp_pkg::TS_W-1:0]    rsp_key_total_ticks,
   output logic [nrtp_pkg::ENT_W-1:0]   rsp_key_entrances,
   output logic [nrtp_pkg::DEPTH_W-1:0] rsp_stack_depth
);
   import nrtp_pkg::*;

   // only keys 0..7 can be named by a request, so only those get counters
   localparam int NT  = ((KEY_COUNT < 7) ? KEY_COUNT : 7) + 1;
   localparam int IW  = $clog2(NT);
   localparam int KW  = ($clog2(KEY_COUNT + 1) > KEY_W) ? $clog2(KEY_COUNT + 1) : KEY_W;
   localparam int CW  = $clog2(STACK_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [MASK_W-1:0]  mask_ff;
   logic [SAVED_W-1:0] elapsed_ff, elapsed_in;
   logic [KW-1:0]      done_ff;
   logic               apply_ff, apply_in;
   logic               track_ff, track_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [TS_W-1:0]    rsp_total_ff, rsp_total_in;
   logic [ENT_W-1:0]   rsp_ent_ff, rsp_ent_in;

   logic               accept;
   logic               key_ok;
   logic               full;
   logic               empty;
   logic               do_push;
   logic               do_pop;
   req_kind_type       kind;
   cell_ctrl_type      cell_ctrl;
   bank_cmd_type       bank_cmd;
   logic [IW-1:0]      bank_idx;
   logic [TS_W-1:0]    bank_total;
   logic [ENT_W-1:0]   bank_ent;

   logic [KW-1:0]      cell_key   [STACK_DEPTH];
   logic [SAVED_W-1:0] cell_saved [STACK_DEPTH];
   logic [KW-1:0]      top_key;

   assign kind    = req_kind_type'(req_type);
   assign busy    = (state_ff == S_END);
   assign accept  = start && !busy;
   assign key_ok  = (32'(req_region_key) <= KEY_COUNT);
   assign full    = (count_ff >= CW'(STACK_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = accept && (kind == REQ_BEGIN) && key_ok && !full;
   assign do_pop  = accept && (kind == REQ_END) && !empty;
   assign top_key = cell_key[0];

   // enable mask register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= {MASK_W{1'b1}};
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------
   // region stack: row of cells, top of stack in cell 0
   // ---------------------------------------------------------------
   assign cell_ctrl = '{push: do_push, pop: do_pop, sub: busy && apply_ff};

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [KW-1:0]      up_key;
      logic [SAVED_W-1:0] up_saved;
      logic [KW-1:0]      dn_key;
      logic [SAVED_W-1:0] dn_saved;

      if (i == 0) begin : g_head
         // a begin stores minus the timestamp
         assign up_key   = KW'(req_region_key);
         assign up_saved = '0 - {{(SAVED_W-TS_W){1'b0}}, req_timestamp};
      end else begin : g_body
         assign up_key   = cell_key[i-1];
         assign up_saved = cell_saved[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_tail
         assign dn_key   = cell_key[i];
         assign dn_saved = cell_saved[i];
      end else begin : g_mid
         assign dn_key   = cell_key[i+1];
         assign dn_saved = cell_saved[i+1];
      end

      nrtp_cell #(
         .KW        (KW),
         .RESET_KEY (KEY_COUNT)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .up_key   (up_key),
         .up_saved (up_saved),
         .dn_key   (dn_key),
         .dn_saved (dn_saved),
         .elapsed  (elapsed_ff),
         .key      (cell_key[i]),
         .saved    (cell_saved[i])
      );
   end

   // ---------------------------------------------------------------
   // per-key counters, one index per cycle: request key when idle,
   // popped key while busy with an end
   // ---------------------------------------------------------------
   assign bank_idx = busy ? done_ff[IW-1:0] : req_region_key[IW-1:0];
   assign bank_cmd = '{bump: do_push && (32'(req_region_key) < NT),
                       add:  busy && apply_ff && track_ff};

   nrtp_key_bank #(
      .NT        (NT),
      .CATCH_IDX (KEY_COUNT)
   ) u_bank (
      .clock     (clock),
      .reset     (reset),
      .cmd       (bank_cmd),
      .idx       (bank_idx),
      .add_val   (elapsed_ff),
      .sel_total (bank_total),
      .sel_ent   (bank_ent)
   );

   // ---------------------------------------------------------------
   // control
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= CW'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (do_pop) begin
         elapsed_ff <= elapsed_in;
         done_ff    <= top_key;
         apply_ff   <= apply_in;
         track_ff   <= track_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_ent_ff    <= rsp_ent_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_total_in  = '0;
      rsp_ent_in    = '0;
      // elapsed of the top entry; keys above six have no mask bit
      elapsed_in    = cell_saved[0] + {{(SAVED_W-TS_W){1'b0}}, req_timestamp};
      apply_in      = (32'(top_key) > 6) || mask_ff[top_key[2:0]];
      track_in      = (32'(top_key) < NT);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               case (kind)
                  REQ_BEGIN: begin
                     if (!key_ok) begin
                        rsp_status_in = ST_BAD_KEY;
                     end else if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  REQ_END: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        // result goes out after the subtract cycle
                        count_in      = count_ff - CW'(1);
                        rsp_strobe_in = 1'b0;
                        state_in      = S_END;
                     end
                  end
                  REQ_READ: begin
                     if (!key_ok) begin
                        rsp_status_in = ST_BAD_KEY;
                     end else begin
                        rsp_total_in = bank_total;
                        rsp_ent_in   = bank_ent;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_END: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result ports; depth is the count after the reported word
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_key_total_ticks = rsp_total_ff;
   assign rsp_key_entrances   = rsp_ent_ff;
   assign rsp_stack_depth     = DEPTH_W'(count_ff);

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held for more than one cycle");

   a_pop_busy: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> (busy && !rsp_strobe))
      else $error("pop did not enter the subtract cycle");

   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      ((accept && !do_pop) || busy) |=> rsp_strobe)
      else $error("finished word gave no result");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("stack count moved without a word");

endmodule

/* sv/nrtp_cell.sv */
// one stack cell: holds a region key and its saved tick value
// depends on nrtp_pkg
module nrtp_cell #(
   parameter int KW        = 3,
   parameter int RESET_KEY = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  nrtp_pkg::cell_ctrl_type      ctrl,
   input  logic [KW-1:0]                up_key,
   input  logic [nrtp_pkg::SAVED_W-1:0] up_saved,
   input  logic [KW-1:0]                dn_key,
   input  logic [nrtp_pkg::SAVED_W-1:0] dn_saved,
   input  logic [nrtp_pkg::SAVED_W-1:0] elapsed,
   output logic [KW-1:0]                key,
   output logic [nrtp_pkg::SAVED_W-1:0] saved
);
   import nrtp_pkg::*;

   logic [KW-1:0]      key_ff;
   logic [SAVED_W-1:0] saved_ff;

   // push shifts away from the top, pop shifts toward it
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= KW'(RESET_KEY);
         saved_ff <= '0;
      end else if (ctrl.push) begin
         key_ff   <= up_key;
         saved_ff <= up_saved;
      end else if (ctrl.pop) begin
         key_ff   <= dn_key;
         saved_ff <= dn_saved;
      end else if (ctrl.sub) begin
         saved_ff <= saved_ff - elapsed;
      end
   end

   assign key   = key_ff;
   assign saved = saved_ff;

endmodule

/* sv/nrtp_key_bank.sv */
// per-key exclusive tick totals and entrance counters
// depends on nrtp_pkg
module nrtp_key_bank #(
   parameter int  NT        = 7,
   parameter int  CATCH_IDX = 6,
   localparam int IW        = $clog2(NT)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  nrtp_pkg::bank_cmd_type       cmd,
   input  logic [IW-1:0]                idx,
   input  logic [nrtp_pkg::SAVED_W-1:0] add_val,
   output logic [nrtp_pkg::TS_W-1:0]    sel_total,
   output logic [nrtp_pkg::ENT_W-1:0]   sel_ent
);
   import nrtp_pkg::*;

   logic [TS_W-1:0]  total_ff [NT];
   logic [ENT_W-1:0] ent_ff   [NT];

   assign sel_total = total_ff[idx];
   assign sel_ent   = ent_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NT; k++) begin
            total_ff[k] <= '0;
            ent_ff[k]   <= (k == CATCH_IDX) ? ENT_W'(1) : '0;
         end
      end else begin
         if (cmd.bump && (sel_ent != ENT_MAX)) begin
            ent_ff[idx] <= sel_ent + ENT_W'(1);
         end
         if (cmd.add) begin
            total_ff[idx] <= sat_add(sel_total, add_val);
         end
      end
   end

   // the two commands come from different request kinds
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.bump && cmd.add))
      else $error("bump and add in the same cycle");

   a_ent_sat: assert property (@(posedge clock) disable iff (reset)
      (cmd.bump && sel_ent == ENT_MAX) |=> ent_ff[$past(idx)] == ENT_MAX)
      else $error("entrance counter wrapped");

   a_ent_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.bump |=> ent_ff[$past(idx)] != '0)
      else $error("entrance counter zero after a bump");

endmodule
